### src/btc_pkg.sv
package btc_pkg;

   // Default placement of the radix point and size of the digit store
   localparam int POINT_SLOT_DEFAULT  = 30;
   localparam int STORE_DEPTH_DEFAULT = 60;

   // Largest supported divisor exponent (divisor = 3^MAX_POWER)
   localparam int MAX_POWER = 20;
   localparam int POW_W     = 5;

   // Depth of the job queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // ceil(2^33 / 3): x / 3 == (x * DIV3_RECIP) >> 33 for any 32-bit x
   localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

   // Output symbol codes
   localparam logic [1:0] SYM_ZERO  = 2'd0;
   localparam logic [1:0] SYM_ONE   = 2'd1;
   localparam logic [1:0] SYM_MINUS = 2'd2;
   localparam logic [1:0] SYM_POINT = 2'd3;

   typedef enum logic [1:0] {
      JOB_BAD,
      JOB_ZERO,
      JOB_CONV
   } job_kind_type;

   typedef struct packed {
      logic [31:0]      dividend;
      logic [POW_W-1:0] power;
      job_kind_type     kind;
   } job_type;

   function automatic logic [31:0] pow3_value(input logic [POW_W-1:0] k);
      logic [31:0] p;
      case (k)
         5'd0:    p = 32'd1;
         5'd1:    p = 32'd3;
         5'd2:    p = 32'd9;
         5'd3:    p = 32'd27;
         5'd4:    p = 32'd81;
         5'd5:    p = 32'd243;
         5'd6:    p = 32'd729;
         5'd7:    p = 32'd2187;
         5'd8:    p = 32'd6561;
         5'd9:    p = 32'd19683;
         5'd10:   p = 32'd59049;
         5'd11:   p = 32'd177147;
         5'd12:   p = 32'd531441;
         5'd13:   p = 32'd1594323;
         5'd14:   p = 32'd4782969;
         5'd15:   p = 32'd14348907;
         5'd16:   p = 32'd43046721;
         5'd17:   p = 32'd129140163;
         5'd18:   p = 32'd387420489;
         5'd19:   p = 32'd1162261467;
         5'd20:   p = 32'd3486784401;
         default: p = 32'd0;
      endcase
      return p;
   endfunction

endpackage

### src/btc_req_if.sv
interface btc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] dividend;
   logic [31:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

### src/btc_rsp_if.sv
interface btc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] symbol;
   logic       last;
   logic       bad_divisor;

   modport source (output valid, output symbol, output last, output bad_divisor, input ready);
   modport sink   (input valid, input symbol, input last, input bad_divisor, output ready);
endinterface

### src/btc_front.sv
module btc_front
   import btc_pkg::*;
(
   btc_req_if.sink  req_port,
   input  logic     queue_full,
   output logic     push,
   output job_type  push_job
);

   logic             hit;
   logic [POW_W-1:0] power;

   // match divisor against every power of three in parallel
   always_comb begin
      hit   = 1'b0;
      power = '0;
      for (int i = 0; i <= MAX_POWER; i++) begin
         if (req_port.divisor == pow3_value(POW_W'(i))) begin
            hit   = 1'b1;
            power = POW_W'(i);
         end
      end
   end

   always_comb begin
      push_job.dividend = req_port.dividend;
      push_job.power    = power;
      if (!hit) begin
         push_job.kind = JOB_BAD;
      end else if (req_port.dividend == 32'd0) begin
         push_job.kind = JOB_ZERO;
      end else begin
         push_job.kind = JOB_CONV;
      end
   end

   assign req_port.ready = !queue_full;
   assign push           = req_port.valid && !queue_full;

endmodule

### src/btc_queue.sv
module btc_queue
   import btc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### src/btc_engine.sv
module btc_engine
   import btc_pkg::*;
#(
   parameter int POINT_SLOT  = POINT_SLOT_DEFAULT,
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  job_type   head_job,
   output logic      pop,
   btc_rsp_if.source rsp_port
);

   // slots reach POINT_SLOT + MAX_POWER - 1 at most; also must hold STORE_DEPTH
   localparam int SLOT_SPAN = (POINT_SLOT + MAX_POWER + 2 > STORE_DEPTH + 1) ?
                              POINT_SLOT + MAX_POWER + 2 : STORE_DEPTH + 1;
   localparam int SLOT_W    = $clog2(SLOT_SPAN);
   localparam int IDX_W     = $clog2(STORE_DEPTH);
   localparam logic [SLOT_W-1:0] POINT_POS = SLOT_W'(POINT_SLOT);
   localparam logic [SLOT_W-1:0] DEPTH_LIM = SLOT_W'(STORE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXTRACT,
      S_CARRY,
      S_SETUP,
      S_LEAD,
      S_LPOINT,
      S_DIGIT
   } state_type;

   state_type          state_ff,   state_in;
   logic [31:0]        work_ff,    work_in;
   logic [POW_W-1:0]   power_ff,   power_in;
   logic [POW_W-1:0]   pos_ff,     pos_in;
   logic               carry_ff,   carry_in;
   logic               active_ff,  active_in;
   logic [SLOT_W-1:0]  first_ff,   first_in;
   logic [SLOT_W-1:0]  final_ff,   final_in;
   logic [SLOT_W-1:0]  slot_ff,    slot_in;
   logic               pt_done_ff, pt_done_in;
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_sym_ff,   out_sym_in;
   logic               out_last_ff,  out_last_in;
   logic               out_bad_ff,   out_bad_in;

   logic [1:0]         digit_store [STORE_DEPTH];
   logic [1:0]         rd_data_ff;

   logic               can_load;
   logic [63:0]        prod;
   logic [31:0]        work_next;
   logic [31:0]        rem_full;
   logic [1:0]         digit;
   logic               take;
   logic               more;
   logic [SLOT_W-1:0]  ext_slot;
   logic               ext_in_range;
   logic [2:0]         sum;
   logic               cout;
   logic [1:0]         mod3;
   logic [1:0]         bal_sym;
   logic               mem_we;
   logic [SLOT_W-1:0]  wr_slot;
   logic [1:0]         wr_data;
   logic [SLOT_W-1:0]  rd_slot;
   logic [IDX_W-1:0]   wr_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic               point_now;
   logic               at_final;

   assign can_load = !out_valid_ff || rsp_port.ready;

   // one ternary digit per cycle, least significant first
   assign prod      = 64'(work_ff) * 64'(DIV3_RECIP);
   assign work_next = {1'b0, prod[63:33]};
   assign rem_full  = work_ff - {work_next[30:0], 1'b0} - work_next;
   assign digit     = rem_full[1:0];

   // skip trailing zero fraction digits; the point position always counts
   assign take = active_ff || (digit != 2'd0) || (pos_ff == power_ff);
   assign more = (({1'b0, pos_ff} + 1'b1) < {1'b0, power_ff}) || (work_next != 32'd0);

   assign ext_slot     = POINT_POS + SLOT_W'(power_ff) - SLOT_W'(pos_ff) - 1'b1;
   assign ext_in_range = ext_slot < DEPTH_LIM;

   // add one with carry, then map back to digit minus one
   assign sum     = 3'((ext_in_range ? digit : 2'd0)) + 3'(carry_ff) + 3'd1;
   assign cout    = sum >= 3'd3;
   assign mod3    = cout ? 2'(sum - 3'd3) : sum[1:0];
   assign bal_sym = (mod3 == 2'd0) ? SYM_MINUS : mod3 - 2'd1;

   assign point_now = (first_ff < POINT_POS) && (slot_ff == POINT_POS) && !pt_done_ff;
   assign at_final  = (slot_ff == final_ff);

   assign wr_idx = wr_slot[IDX_W-1:0];
   assign rd_idx = (rd_slot < DEPTH_LIM) ? rd_slot[IDX_W-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      power_in     = power_ff;
      pos_in       = pos_ff;
      carry_in     = carry_ff;
      active_in    = active_ff;
      first_in     = first_ff;
      final_in     = final_ff;
      slot_in      = slot_ff;
      pt_done_in   = pt_done_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      wr_slot      = ext_slot;
      wr_data      = bal_sym;
      rd_slot      = slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head_job.kind)
                  JOB_CONV: begin
                     pop       = 1'b1;
                     work_in   = head_job.dividend;
                     power_in  = head_job.power;
                     pos_in    = '0;
                     carry_in  = 1'b0;
                     active_in = 1'b0;
                     state_in  = S_EXTRACT;
                  end
                  JOB_BAD: begin
                     if (can_load) begin
                        pop          = 1'b1;
                        out_valid_in = 1'b1;
                        out_sym_in   = SYM_ZERO;
                        out_last_in  = 1'b1;
                        out_bad_in   = 1'b1;
                     end
                  end
                  default: begin
                     if (can_load) begin
                        pop          = 1'b1;
                        out_valid_in = 1'b1;
                        out_sym_in   = SYM_ZERO;
                        out_last_in  = 1'b1;
                        out_bad_in   = 1'b0;
                     end
                  end
               endcase
            end
         end
         S_EXTRACT: begin
            work_in = work_next;
            pos_in  = pos_ff + 1'b1;
            if (take) begin
               mem_we    = ext_in_range;
               carry_in  = cout;
               active_in = 1'b1;
               first_in  = ext_slot;
               if (!active_ff) begin
                  final_in = ext_slot;
               end
               if (!more) begin
                  state_in = cout ? S_CARRY : S_SETUP;
               end
            end
         end
         S_CARRY: begin
            // carry out of the top digit makes a new leading digit of one
            wr_slot  = first_ff - 1'b1;
            wr_data  = SYM_ONE;
            mem_we   = (first_ff - 1'b1) < DEPTH_LIM;
            first_in = first_ff - 1'b1;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            slot_in    = first_ff;
            rd_slot    = first_ff;
            pt_done_in = 1'b0;
            state_in   = (first_ff >= POINT_POS) ? S_LEAD : S_DIGIT;
         end
         S_LEAD: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_sym_in   = SYM_ZERO;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               state_in     = S_LPOINT;
            end
         end
         S_LPOINT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_sym_in   = SYM_POINT;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               state_in     = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_bad_in   = 1'b0;
               if (point_now) begin
                  out_sym_in  = SYM_POINT;
                  out_last_in = 1'b0;
                  pt_done_in  = 1'b1;
               end else begin
                  out_sym_in  = (slot_ff < DEPTH_LIM) ? rd_data_ff : SYM_ZERO;
                  out_last_in = at_final;
                  if (at_final) begin
                     state_in = S_IDLE;
                  end else begin
                     slot_in = slot_ff + 1'b1;
                     rd_slot = slot_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         carry_ff     <= 1'b0;
         active_ff    <= 1'b0;
         pt_done_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         carry_ff     <= carry_in;
         active_ff    <= active_in;
         pt_done_ff   <= pt_done_in;
      end
      work_ff     <= work_in;
      power_ff    <= power_in;
      pos_ff      <= pos_in;
      first_ff    <= first_in;
      final_ff    <= final_in;
      slot_ff     <= slot_in;
      out_sym_ff  <= out_sym_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   // digit store: one write, one registered read tracking the emit cursor
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_store[wr_idx] <= wr_data;
      end
      rd_data_ff <= digit_store[rd_idx];
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.symbol      = out_sym_ff;
   assign rsp_port.last        = out_last_ff;
   assign rsp_port.bad_divisor = out_bad_ff;

endmodule

### src/balanced_ternary_converter_top.sv
// Balanced ternary converter.
// req_port carries a request (dividend, divisor); the divisor must be 3^0..3^20.
// rsp_port returns the quotient as balanced ternary symbols, most significant
// first: 0, 1, 2 for minus one, 3 for the radix point; last marks the final
// symbol of a request. A bad divisor gives one symbol with bad_divisor set,
// a zero dividend one zero symbol.
// The front end classifies each request as it is taken and places it in a
// two-entry queue; req_port.ready drops only when that queue is full.
// The back end picks up a request, extracts the ternary digits of the dividend
// up to the highest one needed (at most 21), adds a leading one for a carry out
// of the top digit, runs a setup step, then emits the symbols in order; a bad
// divisor or zero dividend gets its one symbol straight from idle.
// A stalled rsp_port holds its symbol and pauses symbol emission; the front
// keeps taking requests until the queue fills. Reset empties the queue and
// returns the back end to idle; the digit store needs no clearing.
module balanced_ternary_converter_top
   import btc_pkg::*;
#(
   parameter int POINT_SLOT  = POINT_SLOT_DEFAULT,
   parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   btc_req_if.sink   req_port,
   btc_rsp_if.source rsp_port
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // front: divisor check and zero detect at request time
   btc_front u_front (
      .req_port   (req_port),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // decouples request intake from the digit engine
   btc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: digit extraction with carry, then symbol emission
   btc_engine #(
      .POINT_SLOT  (POINT_SLOT),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_port   (rsp_port)
   );

endmodule
